FILE: src/tbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbu_pkg;

   // magnitudes are cut down to this many bits before squaring
   localparam int NORM_BITS = 30;
   // deltas of fields wider than this are floored down so the products stay in range
   localparam int MAX_DELTA_BITS = 24;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage
`default_nettype wire

FILE: src/triangle_tangent_basis_unit.sv
// Per-triangle tangent and bitangent unit.
// req_ channel: one vertex per word, already in triangle-list order; every
// third word closes a triangle. rsp_ channel: one word per triangle with the
// unit tangent and bitangent in signed Q1.(OUT_FRAC_BITS); rsp_tuser set
// marks a degenerate triangle (zero determinant or zero-length vector) and
// its vectors are then all zero.
// The first two corners of a triangle are always accepted. The
// closing corner goes into a two-entry queue of edge and uv deltas; the back
// end works one triangle at a time through a shared multiplier (14 products),
// then per vector a 32-step square root and three 15-step divisions.
// The time from the closing corner to rsp_tvalid depends on the pre-scaling
// shifts. The back end takes a new triangle only once the last result has
// gone to the output register; a zero determinant ends once all products are
// in and a zero-length vector as soon as its square root is known.
// Reset clears the corner count, the queue and rsp_tvalid; stored corners are
// not cleared. A stalled rsp_ word is held in the output register while the
// next triangle is worked on; the queue then fills and req_tready drops only on
// a closing corner.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_basis_unit #(
   parameter int COORD_BITS    = 16,
   parameter int UV_BITS       = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v
   input  wire logic [((3*COORD_BITS+2*UV_BITS+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
   output logic [((6*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic      rsp_tuser
);
   localparam int PS  = (COORD_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                        (COORD_BITS - tbu_pkg::MAX_DELTA_BITS) : 0;
   localparam int TS  = (UV_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                        (UV_BITS - tbu_pkg::MAX_DELTA_BITS) : 0;
   localparam int EW  = 6*(COORD_BITS+1-PS) + 4*(UV_BITS+1-TS);
   localparam int IFW = 3*COORD_BITS + 2*UV_BITS;
   localparam int OFW = 6*(OUT_FRAC_BITS+2);
   localparam int OTW = ((OFW+7)/8)*8;

   tbu_pkg::q_stat_type q_stat;
   logic q_push, q_pop;
   logic [EW-1:0] push_data, pop_data;
   logic [OFW-1:0] rsp_fields;

   tbu_front #(
      .COORD_BITS(COORD_BITS),
      .UV_BITS   (UV_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_fields(req_tdata[IFW-1:0]),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (push_data)
   );

   tbu_queue #(
      .WIDTH(EW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_data),
      .pop      (q_pop),
      .pop_data (pop_data),
      .stat     (q_stat)
   );

   tbu_back #(
      .COORD_BITS   (COORD_BITS),
      .UV_BITS      (UV_BITS),
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_fields(rsp_fields),
      .rsp_flag  (rsp_tuser)
   );

   assign rsp_tdata = OTW'(rsp_fields);

endmodule
`default_nettype wire

FILE: src/tbu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tbu_front #(
   parameter int COORD_BITS    = 16,
   parameter int UV_BITS       = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [3*COORD_BITS+2*UV_BITS-1:0] req_fields,
   input  wire tbu_pkg::q_stat_type         q_stat,
   output logic                             q_push,
   output logic [6*(COORD_BITS+1-((COORD_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                 (COORD_BITS - tbu_pkg::MAX_DELTA_BITS) : 0)) +
                 4*(UV_BITS+1-((UV_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                 (UV_BITS - tbu_pkg::MAX_DELTA_BITS) : 0))-1:0] q_data
);
   localparam int PS  = (COORD_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                        (COORD_BITS - tbu_pkg::MAX_DELTA_BITS) : 0;
   localparam int TS  = (UV_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                        (UV_BITS - tbu_pkg::MAX_DELTA_BITS) : 0;
   localparam int PDW = COORD_BITS + 1 - PS;
   localparam int TDW = UV_BITS + 1 - TS;

   logic [1:0] count_ff, count_in;
   logic signed [COORD_BITS-1:0] pos_ff [2][3];
   logic signed [UV_BITS-1:0]    tex_ff [2][2];
   logic signed [COORD_BITS-1:0] pos_w [3];
   logic signed [UV_BITS-1:0]    tex_w [2];
   logic signed [COORD_BITS:0]   pdiff1 [3];
   logic signed [COORD_BITS:0]   pdiff2 [3];
   logic signed [UV_BITS:0]      tdiff1 [2];
   logic signed [UV_BITS:0]      tdiff2 [2];
   logic accept;
   logic third;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_w[i] = req_fields[i*COORD_BITS +: COORD_BITS];
      end
      for (int i = 0; i < 2; i++) begin
         tex_w[i] = req_fields[3*COORD_BITS + i*UV_BITS +: UV_BITS];
      end
   end

   assign third      = (count_ff >= 2'd2);
   assign req_tready = !third || !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && third;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = third ? 2'd0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // corner store, no reset: always written before it is read
   always_ff @(posedge clock) begin
      if (accept && !third) begin
         pos_ff[count_ff[0]] <= pos_w;
         tex_ff[count_ff[0]] <= tex_w;
      end
   end

   // deltas against the first corner, floored when the fields are wide
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pdiff1[i] = (COORD_BITS+1)'(pos_ff[1][i]) - (COORD_BITS+1)'(pos_ff[0][i]);
         pdiff2[i] = (COORD_BITS+1)'(pos_w[i]) - (COORD_BITS+1)'(pos_ff[0][i]);
      end
      for (int i = 0; i < 2; i++) begin
         tdiff1[i] = (UV_BITS+1)'(tex_ff[1][i]) - (UV_BITS+1)'(tex_ff[0][i]);
         tdiff2[i] = (UV_BITS+1)'(tex_w[i]) - (UV_BITS+1)'(tex_ff[0][i]);
      end
      for (int i = 0; i < 3; i++) begin
         q_data[i*PDW +: PDW]     = PDW'(pdiff1[i] >>> PS);
         q_data[(3+i)*PDW +: PDW] = PDW'(pdiff2[i] >>> PS);
      end
      q_data[6*PDW +: TDW]         = TDW'(tdiff1[0] >>> TS);
      q_data[6*PDW + TDW +: TDW]   = TDW'(tdiff1[1] >>> TS);
      q_data[6*PDW + 2*TDW +: TDW] = TDW'(tdiff2[0] >>> TS);
      q_data[6*PDW + 3*TDW +: TDW] = TDW'(tdiff2[1] >>> TS);
   end

endmodule
`default_nettype wire

FILE: src/tbu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tbu_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output tbu_pkg::q_stat_type   stat
);
   logic [WIDTH-1:0] entry_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   assign stat.full  = (fill_ff == 2'd2);
   assign stat.empty = (fill_ff == 2'd0);
   assign pop_data   = entry_ff[rd_ff];

   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = pop ? !rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/tbu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tbu_back #(
   parameter int COORD_BITS    = 16,
   parameter int UV_BITS       = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tbu_pkg::q_stat_type         q_stat,
   input  wire logic [6*(COORD_BITS+1-((COORD_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                 (COORD_BITS - tbu_pkg::MAX_DELTA_BITS) : 0)) +
                 4*(UV_BITS+1-((UV_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                 (UV_BITS - tbu_pkg::MAX_DELTA_BITS) : 0))-1:0] q_data,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [6*(OUT_FRAC_BITS+2)-1:0]   rsp_fields,
   output logic                             rsp_flag
);
   localparam int PS   = (COORD_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                         (COORD_BITS - tbu_pkg::MAX_DELTA_BITS) : 0;
   localparam int TS   = (UV_BITS > tbu_pkg::MAX_DELTA_BITS) ?
                         (UV_BITS - tbu_pkg::MAX_DELTA_BITS) : 0;
   localparam int PDW  = COORD_BITS + 1 - PS;
   localparam int TDW  = UV_BITS + 1 - TS;
   localparam int OPW  = (PDW > TDW) ? PDW : TDW;
   localparam int RW   = 2*OPW + 1;
   localparam int NORM = tbu_pkg::NORM_BITS;
   localparam int MWX  = (RW > NORM) ? RW : NORM;
   localparam int SQW  = 2*NORM + 2;
   localparam int BW   = SQW + 1;
   localparam int LENW = NORM + 1;
   localparam int QB   = OUT_FRAC_BITS + 1;
   localparam int DVW  = LENW + QB;
   localparam int OW   = OUT_FRAC_BITS + 2;
   localparam int DCW  = $clog2(QB + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_DRAIN = 8'b0000_0100,
      S_LOAD  = 8'b0000_1000,
      S_SCALE = 8'b0001_0000,
      S_SQ    = 8'b0010_0000,
      S_ROOT  = 8'b0100_0000,
      S_DIV   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   logic out_pend_ff;

   logic signed [PDW-1:0] dp1_ff [3];
   logic signed [PDW-1:0] dp2_ff [3];
   logic signed [TDW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   logic [3:0] k_ff, kd_ff;
   logic pv_ff;
   logic signed [OPW-1:0] opa, opb;
   logic signed [2*OPW-1:0] prod_ff;
   logic signed [RW-1:0] acc_ff;
   logic signed [RW-1:0] res_ff [7];

   logic vsel_ff;
   logic signed [RW-1:0] comp [3];
   logic [MWX-1:0] mag_ff [3];
   logic neg_ff [3];
   logic [MWX-1:0] mag_or;

   logic [1:0] j_ff;
   logic [NORM-1:0] sqa;
   logic [2*NORM-1:0] sq_ff;
   logic [SQW-1:0] sum_ff;
   logic [BW-1:0] root_ff, bit_ff, trial;

   logic [1:0] ci_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [DVW-1:0] rem_ff, dvs_ff;
   logic [QB-1:0] q_ff, qn, qs;
   logic qbit;
   logic [LENW-1:0] len;
   logic [NORM-1:0] mag_sel;
   logic sign_sel;
   logic [OW-1:0] outv_ff [6];
   logic deg_ff;

   assign q_pop = (state_ff == S_IDLE) && !q_stat.empty && !out_pend_ff;

   // product schedule: three tangent, three bitangent, then the determinant
   always_comb begin
      opa = '0;
      opb = '0;
      unique case (k_ff[3:1])
         3'd0, 3'd1, 3'd2: begin
            opa = k_ff[0] ? OPW'(dp2_ff[k_ff[2:1]]) : OPW'(dp1_ff[k_ff[2:1]]);
            opb = k_ff[0] ? OPW'(dv1_ff) : OPW'(dv2_ff);
         end
         3'd3, 3'd4, 3'd5: begin
            opa = k_ff[0] ? OPW'(dp1_ff[2'(k_ff[3:1] - 3'd3)])
                          : OPW'(dp2_ff[2'(k_ff[3:1] - 3'd3)]);
            opb = k_ff[0] ? OPW'(du2_ff) : OPW'(du1_ff);
         end
         3'd6: begin
            opa = k_ff[0] ? OPW'(dv1_ff) : OPW'(du1_ff);
            opb = k_ff[0] ? OPW'(du2_ff) : OPW'(dv2_ff);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp[i] = vsel_ff ? res_ff[3+i] : res_ff[i];
      end
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      unique case (j_ff)
         2'd0:    sqa = mag_ff[0][NORM-1:0];
         2'd1:    sqa = mag_ff[1][NORM-1:0];
         2'd2:    sqa = mag_ff[2][NORM-1:0];
         default: sqa = '0;
      endcase
      unique case (ci_ff)
         2'd0:    begin mag_sel = mag_ff[0][NORM-1:0]; sign_sel = neg_ff[0]; end
         2'd1:    begin mag_sel = mag_ff[1][NORM-1:0]; sign_sel = neg_ff[1]; end
         2'd2:    begin mag_sel = mag_ff[2][NORM-1:0]; sign_sel = neg_ff[2]; end
         default: begin mag_sel = '0; sign_sel = 1'b0; end
      endcase
      trial = root_ff + bit_ff;
      len   = root_ff[LENW-1:0];
      qbit  = (rem_ff >= dvs_ff);
      qn    = {q_ff[QB-2:0], qbit};
      qs    = (qn > (QB'(1) << OUT_FRAC_BITS)) ? (QB'(1) << OUT_FRAC_BITS) : qn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pv_ff       <= 1'b0;
         out_pend_ff <= 1'b0;
         rsp_tvalid  <= 1'b0;
         deg_ff      <= 1'b0;
      end else begin
         pv_ff <= (state_ff == S_MUL);
         if (rsp_tvalid && rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
         if (out_pend_ff && (!rsp_tvalid || rsp_tready)) begin
            rsp_tvalid  <= 1'b1;
            out_pend_ff <= 1'b0;
            deg_ff      <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (k_ff == 4'd13) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (res_ff[6] == '0) begin
                  deg_ff      <= 1'b1;
                  out_pend_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               if ((mag_or >> NORM) == '0) begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (j_ff == 2'd3) begin
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (bit_ff[0]) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (len == '0) begin
                  deg_ff      <= 1'b1;
                  out_pend_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end else if (dcnt_ff == DCW'(QB-1) && ci_ff == 2'd2) begin
                  if (vsel_ff) begin
                     out_pend_ff <= 1'b1;
                     state_ff    <= S_IDLE;
                  end else begin
                     state_ff <= S_LOAD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < 3; i++) begin
            dp1_ff[i] <= q_data[i*PDW +: PDW];
            dp2_ff[i] <= q_data[(3+i)*PDW +: PDW];
         end
         du1_ff  <= q_data[6*PDW +: TDW];
         dv1_ff  <= q_data[6*PDW + TDW +: TDW];
         du2_ff  <= q_data[6*PDW + 2*TDW +: TDW];
         dv2_ff  <= q_data[6*PDW + 3*TDW +: TDW];
         k_ff    <= 4'd0;
         vsel_ff <= 1'b0;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= opa * opb;
         kd_ff   <= k_ff;
         k_ff    <= k_ff + 4'd1;
      end
      // pair of products: first one held, second subtracted and shifted in
      if (pv_ff) begin
         if (!kd_ff[0]) begin
            acc_ff <= RW'(prod_ff);
         end else begin
            for (int i = 0; i < 6; i++) begin
               res_ff[i] <= res_ff[i+1];
            end
            res_ff[6] <= acc_ff - RW'(prod_ff);
         end
      end
      if (state_ff == S_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= MWX'(unsigned'(comp[i] < 0 ? -comp[i] : comp[i]));
            neg_ff[i] <= (comp[i] < 0) ^ (res_ff[6] < 0);
         end
      end
      if (state_ff == S_SCALE) begin
         if ((mag_or >> NORM) != '0) begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_ff[i] >> 1;
            end
         end else begin
            j_ff   <= 2'd0;
            sum_ff <= '0;
         end
      end
      if (state_ff == S_SQ) begin
         sq_ff <= sqa * sqa;
         j_ff  <= j_ff + 2'd1;
         if (j_ff != 2'd0) begin
            sum_ff <= sum_ff + SQW'(sq_ff);
         end
         if (j_ff == 2'd3) begin
            root_ff <= '0;
            bit_ff  <= BW'(1) << (BW-1);
         end
      end
      // one result bit of the square root per cycle
      if (state_ff == S_ROOT) begin
         if ({1'b0, sum_ff} >= trial) begin
            sum_ff  <= SQW'({1'b0, sum_ff} - trial);
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         ci_ff  <= 2'd0;
         if (bit_ff[0]) begin
            dcnt_ff <= DCW'(QB);
         end
      end
      // restoring division, one quotient bit per cycle once a component's operands are loaded
      if (state_ff == S_DIV) begin
         if (dcnt_ff == DCW'(QB)) begin
            if (root_ff != '0 || bit_ff == '0) begin
               rem_ff  <= DVW'({mag_sel, OUT_FRAC_BITS'(0)}) + DVW'(len >> 1);
               dvs_ff  <= DVW'(len) << (QB-1);
               q_ff    <= '0;
               dcnt_ff <= '0;
            end
         end else begin
            if (qbit) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            dvs_ff  <= dvs_ff >> 1;
            q_ff    <= qn;
            dcnt_ff <= dcnt_ff + DCW'(1);
         end
         // the last step finishes a component and primes the next one
         if (dcnt_ff == DCW'(QB-1)) begin
            for (int i = 0; i < 5; i++) begin
               outv_ff[i] <= outv_ff[i+1];
            end
            outv_ff[5] <= sign_sel ? OW'(-OW'(qs)) : OW'(qs);
            ci_ff      <= ci_ff + 2'd1;
            dcnt_ff    <= DCW'(QB);
            if (ci_ff == 2'd2) begin
               vsel_ff <= 1'b1;
            end
         end
      end
      if (out_pend_ff && (!rsp_tvalid || rsp_tready)) begin
         for (int i = 0; i < 6; i++) begin
            rsp_fields[i*OW +: OW] <= deg_ff ? '0 : outv_ff[i];
         end
         rsp_flag <= deg_ff;
      end
   end

endmodule
`default_nettype wire

FILE: src/tbu_check.sv
`timescale 1ns / 1ps
`default_nettype none
module tbu_check #(
   parameter int COORD_BITS    = 16,
   parameter int UV_BITS       = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic [((3*COORD_BITS+2*UV_BITS+7)/8)*8-1:0] req_tdata,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((6*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   input wire logic rsp_tuser
);
   localparam int OW  = OUT_FRAC_BITS + 2;
   localparam int ONE = 2**OUT_FRAC_BITS;

   logic signed [OW-1:0] tan_x, bit_x;
   assign tan_x = rsp_tdata[OW-1:0];
   assign bit_x = rsp_tdata[4*OW-1:3*OW];

   // degenerate words carry zero vectors
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate word with non-zero vectors");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // the x components of both unit vectors never exceed one in magnitude
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         int'(tan_x) <= ONE && int'(tan_x) >= -ONE &&
         int'(bit_x) <= ONE && int'(bit_x) >= -ONE)
      else $error("component out of unit range");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting req word changed");

endmodule

bind triangle_tangent_basis_unit tbu_check #(
   .COORD_BITS   (COORD_BITS),
   .UV_BITS      (UV_BITS),
   .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_check (.*);
`default_nettype wire

FILE: verif/triangle_tangent_basis_unit_test.sv
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_basis_unit_test;

   localparam int CB = 16;
   localparam int UB = 16;
   localparam int OFB = 14;
   localparam int OW = OFB + 2;
   localparam int REQ_W = ((3*CB+2*UB+7)/8)*8;
   localparam int RSP_W = ((6*OW+7)/8)*8;
   localparam int N_RANDOM = 627;
   localparam int CYCLE_LIMIT = 900000;
   localparam int N_DIRECTED = 24;

   typedef struct packed {
      logic signed [15:0] v;
      logic signed [15:0] u;
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } vertex_type;

   typedef struct {
      logic [RSP_W-1:0] vectors;
      logic             degenerate;
   } basis_type;

   typedef struct {
      vertex_type vert;
      logic       typed;
      basis_type  basis;
   } stim_row_type;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tuser;
   logic [REQ_W-1:0] req_tdata;
   logic [RSP_W-1:0] rsp_tdata;

   basis_type basis_queue[$];
   stim_row_type directed_rows[N_DIRECTED];
   vertex_type corner_store[2];
   int corner_idx;
   int mismatches;
   int cycles;
   bit sending_done;

   triangle_tangent_basis_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit unit_vector(input longint c[3], output logic [3*OW-1:0] o);
      longint unsigned mag[3], mx, sum, len, q;
      int b;
      mx = 0;
      sum = 0;
      b = 0;
      o = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? -c[i] : c[i];
         if (mag[i] > mx) mx = mag[i];
      end
      while (b < 64 && (mx >> b) != 0) b++;
      if (b > tbu_pkg::NORM_BITS)
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> (b - tbu_pkg::NORM_BITS);
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      if (sum == 0) return 0;
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << OFB) + len / 2) / len;
         if (q > (64'd1 << OFB)) q = 64'd1 << OFB;
         o[i*OW +: OW] = c[i] < 0 ? OW'(-q) : OW'(q);
      end
      return 1;
   endfunction

   // corners 0 and 1 are stored, the closing corner yields a basis word
   function automatic bit triangle_basis(input vertex_type a, input vertex_type b,
                                         input vertex_type c, output basis_type r);
      longint p0[3], p1[3], p2[3], dp1[3], dp2[3], tn[3], bt[3];
      longint du1, dv1, du2, dv2, det;
      logic [3*OW-1:0] ot, ob;
      p0 = '{a.x, a.y, a.z};
      p1 = '{b.x, b.y, b.z};
      p2 = '{c.x, c.y, c.z};
      du1 = longint'(b.u) - a.u;
      dv1 = longint'(b.v) - a.v;
      du2 = longint'(c.u) - a.u;
      dv2 = longint'(c.v) - a.v;
      det = du1 * dv2 - dv1 * du2;
      for (int i = 0; i < 3; i++) begin
         dp1[i] = p1[i] - p0[i];
         dp2[i] = p2[i] - p0[i];
         tn[i] = dp1[i] * dv2 - dp2[i] * dv1;
         bt[i] = dp2[i] * du1 - dp1[i] * du2;
         if (det < 0) begin
            tn[i] = -tn[i];
            bt[i] = -bt[i];
         end
      end
      r.vectors = '0;
      r.degenerate = 1;
      if (det != 0 && unit_vector(tn, ot) && unit_vector(bt, ob)) begin
         r.vectors = {ob, ot};
         r.degenerate = 0;
      end
      return 1;
   endfunction

   function automatic vertex_type make_vertex(int x, int y, int z, int u, int v);
      vertex_type t;
      t.x = 16'(x);
      t.y = 16'(y);
      t.z = 16'(z);
      t.u = 16'(u);
      t.v = 16'(v);
      return t;
   endfunction

   function automatic vertex_type random_vertex(int mode);
      vertex_type t;
      t = '0;
      if (mode == 0) t = 80'({$urandom, $urandom, $urandom});
      else if (mode == 1) begin
         // small coordinates around the origin
         t.x = 16'($urandom_range(0, 2047) - 1024);
         t.y = 16'($urandom_range(0, 2047) - 1024);
         t.z = 16'($urandom_range(0, 2047) - 1024);
         t.u = 16'($urandom_range(0, 32767) - 16384);
         t.v = 16'($urandom_range(0, 32767) - 16384);
      end else begin
         // extreme values per field, except z which is zero or random
         t.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         t.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         t.z = $urandom_range(0, 2) == 0 ? 16'sh0 : 16'($urandom);
         t.u = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         t.v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      return t;
   endfunction

   function automatic basis_type fixed_basis(logic [RSP_W-1:0] vec, logic degen);
      basis_type r;
      r.vectors = vec;
      r.degenerate = degen;
      return r;
   endfunction

   task automatic send_vertex(input vertex_type t, input bit typed, input basis_type given);
      basis_type r;
      basis_type expected_word;
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= t;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (corner_idx < 2) begin
         corner_store[corner_idx] = t;
         corner_idx++;
      end else begin
         void'(triangle_basis(corner_store[0], corner_store[1], t, r));
         expected_word = typed ? given : r;
         basis_queue.insert(basis_queue.size(), expected_word);
         corner_idx = 0;
      end
      @(negedge clock);
   endtask

   initial begin
      basis_type none;
      none = fixed_basis('0, 0);
      directed_rows[0] = '{make_vertex(0, 0, 0, 0, 0), 0, none};
      directed_rows[1] = '{make_vertex(256, 0, 0, 16384, 0), 0, none};
      directed_rows[2] = '{make_vertex(0, 256, 0, 0, 16384), 1,
                           fixed_basis({16'sd0, 16'sd16384, 16'sd0,
                                        16'sd0, 16'sd0, 16'sd16384}, 0)};
      // zero determinant: identical uv on all corners
      directed_rows[3] = '{make_vertex(100, 5, 9, 7, 7), 0, none};
      directed_rows[4] = '{make_vertex(-300, 50, 9, 7, 7), 0, none};
      directed_rows[5] = '{make_vertex(32767, -32768, 0, 7, 7), 1,
                           fixed_basis('0, 1)};
      // zero-length vectors: all positions equal
      directed_rows[6] = '{make_vertex(12, 12, 12, 0, 0), 0, none};
      directed_rows[7] = '{make_vertex(12, 12, 12, 1000, 0), 0, none};
      directed_rows[8] = '{make_vertex(12, 12, 12, 0, 1000), 1, fixed_basis('0, 1)};
      // negative determinant flips both vectors
      directed_rows[9] = '{make_vertex(0, 0, 0, 0, 0), 0, none};
      directed_rows[10] = '{make_vertex(256, 0, 0, -16384, 0), 0, none};
      directed_rows[11] = '{make_vertex(0, 256, 0, 0, 16384), 0, none};
      // field extremes, then unit values and mixed values
      directed_rows[12] = '{make_vertex(-32768, -32768, -32768, -32768, -32768), 0, none};
      directed_rows[13] = '{make_vertex(32767, 32767, 32767, 32767, -32768), 0, none};
      directed_rows[14] = '{make_vertex(32767, -32768, 32767, -32768, 32767), 0, none};
      directed_rows[15] = '{make_vertex(32767, 32767, 32767, 32767, 32767), 0, none};
      directed_rows[16] = '{make_vertex(-32768, 0, 32767, -32768, 32767), 0, none};
      directed_rows[17] = '{make_vertex(0, 32767, -32768, 32767, -32768), 0, none};
      directed_rows[18] = '{make_vertex(1, -1, 1, -1, 1), 0, none};
      directed_rows[19] = '{make_vertex(-1, 1, -1, 1, 1), 0, none};
      directed_rows[20] = '{make_vertex(1, 1, -1, -1, -1), 0, none};
      directed_rows[21] = '{make_vertex(-21555, 4321, -8, 123, -9999), 0, none};
      directed_rows[22] = '{make_vertex(30000, -29999, 17, -30000, 29999), 0, none};
      directed_rows[23] = '{make_vertex(-1, -32768, 32767, 1, 0), 0, none};

      req_tvalid = 0;
      req_tdata = '0;
      reset = 1;
      corner_idx = 0;
      sending_done = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int i = 0; i < N_DIRECTED; i++)
         send_vertex(directed_rows[i].vert, directed_rows[i].typed, directed_rows[i].basis);
      for (int i = 0; i < N_RANDOM; i++) begin
         int mode;
         mode = $urandom_range(0, 9);
         send_vertex(random_vertex(mode < 2 ? 2 : (mode < 5 ? 0 : 1)), 0, none);
      end
      req_tvalid <= 0;
      sending_done = 1;
   end

   initial begin
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         int stall;
         stall = $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (basis_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected basis word %h %b", rsp_tdata, rsp_tuser);
         end else begin
            basis_type want;
            want = basis_queue.pop_front();
            if (want.vectors !== rsp_tdata || want.degenerate !== rsp_tuser) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("basis mismatch: expected %h %b, got %h %b",
                           want.vectors, want.degenerate, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      cycles = 0;
      fork
         begin
            wait (sending_done && basis_queue.size() == 0);
            repeat (400) @(posedge clock);
         end
         begin
            while (cycles < CYCLE_LIMIT) begin
               @(posedge clock);
               cycles++;
            end
            mismatches++;
         end
      join_any
      if (mismatches == 0 && basis_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
